// ===== rtl/nrc_pkg.sv =====
// Shared types and constants of the normalized rgb convolution core
`timescale 1ns / 1ps
package nrc_pkg;

  // kernel geometry
  localparam int KSIZE = 3;
  localparam int HALF = KSIZE / 2;
  localparam int KK = KSIZE * KSIZE;
  localparam int KW = (KSIZE > 1) ? $clog2(KSIZE) : 1;
  localparam int PW = (KK > 1) ? $clog2(KK) : 1;
  localparam int RING_ROWS = 2 * KSIZE;
  localparam int RW = $clog2(RING_ROWS);
  localparam int MAX_HEIGHT = 1024;

  // arithmetic widths: 9x8 signed product, sums over the kernel
  localparam int PRW = 17;
  localparam int SW = PRW + $clog2(KK) + 1;
  localparam int DW = 8 + $clog2(KK) + 1;
  localparam int XW = SW + 1;

  // request codes
  localparam logic [1:0] REQ_COEF = 2'd0;
  localparam logic [1:0] REQ_PIXEL = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [3:0]        coef_index;
    logic signed [7:0] coef_value;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       last_pixel;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic exec;
    logic win_start;
    logic div_start;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_emit;
    logic emit_ready;
    logic win_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/nrc_ctrl.sv =====
// Controller state machine of the normalized rgb convolution core
`timescale 1ns / 1ps
module nrc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  nrc_pkg::status_t status,
  output nrc_pkg::cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_WIN   = 7'b0001000,
    S_PREP  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = status.req_emit ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        cmd.win_start = status.emit_ready;
        state_next = status.emit_ready ? S_WIN : S_IDLE;
      end
      S_WIN: begin
        if (status.win_done) state_next = S_PREP;
      end
      S_PREP: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        cmd.load = status.out_free;
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/nrc_datapath.sv =====
// Datapath: line memory, window walk, accumulators, divider, output register
`timescale 1ns / 1ps
module nrc_datapath #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  nrc_pkg::in_item_t  in_data,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nrc_pkg::out_item_t out_data,
  input  nrc_pkg::cmd_t      cmd,
  output nrc_pkg::status_t   status
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int NW = WW + 1;
  localparam int CCW = WW + 2;
  localparam int DEPTH = nrc_pkg::RING_ROWS * MAX_WIDTH;
  localparam int AMW = $clog2(DEPTH);

  nrc_pkg::in_item_t item;
  logic [10:0] reg_width, reg_height;
  logic [WW-1:0] w_eff;
  logic [10:0] h_eff;

  logic [CW-1:0] in_col, emit_col;
  logic [10:0] in_row;
  logic [9:0] emit_row;
  logic [nrc_pkg::RW-1:0] in_ring, emit_ring;
  logic frame_done;

  logic signed [7:0] coef [nrc_pkg::KK];
  logic [23:0] mem [DEPTH];
  logic [23:0] rd_q;
  logic [AMW-1:0] rd_addr, wr_addr;

  // effective image size
  always_comb begin
    if (reg_width == 11'd0) w_eff = WW'(1);
    else if (32'(reg_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(reg_width);
    if (reg_height == 11'd0) h_eff = 11'd1;
    else if (32'(reg_height) > nrc_pkg::MAX_HEIGHT) h_eff = 11'(nrc_pkg::MAX_HEIGHT);
    else h_eff = reg_height;
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.take) item <= in_data;
  end

  assign status.req_emit = (item.req_type == nrc_pkg::REQ_PIXEL) ||
                           (item.req_type == nrc_pkg::REQ_FLUSH);

  // coefficient store
  always_ff @(posedge clk) begin
    if (cmd.exec && item.req_type == nrc_pkg::REQ_COEF &&
        32'(item.coef_index) < nrc_pkg::KK) begin
      coef[item.coef_index[nrc_pkg::PW-1:0]] <= item.coef_value;
    end
  end

  // position counters
  logic [WW-1:0] in_col_inc, emit_col_inc;
  logic [10:0] in_row_inc, emit_row_inc;
  logic pix_write, emit_adv;

  assign in_col_inc = WW'(in_col) + WW'(1);
  assign in_row_inc = in_row + 11'd1;
  assign emit_col_inc = WW'(emit_col) + WW'(1);
  assign emit_row_inc = {1'b0, emit_row} + 11'd1;
  assign pix_write = cmd.exec && item.req_type == nrc_pkg::REQ_PIXEL && !frame_done;
  assign emit_adv = cmd.load;
  assign wr_addr = AMW'(in_ring) * AMW'(MAX_WIDTH) + AMW'(in_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width <= 11'd1024;
      reg_height <= 11'd1024;
      in_col <= '0;
      in_row <= '0;
      in_ring <= '0;
      emit_col <= '0;
      emit_row <= '0;
      emit_ring <= '0;
      frame_done <= 1'b0;
    end else if (cfg_valid &&
                 (cfg_index == nrc_pkg::CFG_WIDTH || cfg_index == nrc_pkg::CFG_HEIGHT)) begin
      if (cfg_index == nrc_pkg::CFG_WIDTH) reg_width <= cfg_data;
      else reg_height <= cfg_data;
      in_col <= '0;
      in_row <= '0;
      in_ring <= '0;
      emit_col <= '0;
      emit_row <= '0;
      emit_ring <= '0;
      frame_done <= 1'b0;
    end else begin
      if (pix_write) begin
        if (in_col_inc >= w_eff) begin
          in_col <= '0;
          in_row <= in_row_inc;
          in_ring <= (in_ring == nrc_pkg::RW'(nrc_pkg::RING_ROWS - 1)) ? '0 :
                     in_ring + nrc_pkg::RW'(1);
          if (in_row_inc >= h_eff) frame_done <= 1'b1;
        end else begin
          in_col <= in_col_inc[CW-1:0];
        end
      end
      if (emit_adv) begin
        if (emit_col_inc >= w_eff) begin
          emit_col <= '0;
          if (emit_row_inc >= h_eff) begin
            // frame complete: start over at the origin
            emit_row <= '0;
            emit_ring <= '0;
            in_col <= '0;
            in_row <= '0;
            in_ring <= '0;
            frame_done <= 1'b0;
          end else begin
            emit_row <= emit_row_inc[9:0];
            emit_ring <= (emit_ring == nrc_pkg::RW'(nrc_pkg::RING_ROWS - 1)) ? '0 :
                         emit_ring + nrc_pkg::RW'(1);
          end
        end else begin
          emit_col <= emit_col_inc[CW-1:0];
        end
      end
    end
  end

  // output readiness: bottom-right window pixel already received
  logic [10:0] nr;
  logic [NW-1:0] nc;
  logic emit_ok;
  always_comb begin
    nr = {1'b0, emit_row} + 11'(nrc_pkg::HALF);
    if (nr > h_eff - 11'd1) nr = h_eff - 11'd1;
    nc = NW'(emit_col) + NW'(nrc_pkg::HALF);
    if (nc > NW'(w_eff) - NW'(1)) nc = NW'(w_eff) - NW'(1);
    emit_ok = frame_done || (nr < in_row) ||
              (nr == in_row && nc < NW'(in_col));
  end

  assign status.emit_ready = emit_ok;

  // window walk
  logic issue_act;
  logic [nrc_pkg::KW-1:0] wz, wu;
  logic [nrc_pkg::PW-1:0] wp;
  logic signed [11:0] rr;
  logic signed [CCW-1:0] cc;
  logic in_win, last_issue;
  logic [nrc_pkg::RW:0] ring_t;
  logic [nrc_pkg::RW-1:0] ring_w;

  always_comb begin
    rr = signed'(12'(emit_row)) + signed'(12'(wz)) - signed'(12'(nrc_pkg::HALF));
    cc = signed'(CCW'(emit_col)) + signed'(CCW'(wu)) - signed'(CCW'(nrc_pkg::HALF));
    in_win = !rr[11] && (rr < signed'(12'(h_eff))) &&
             !cc[CCW-1] && (cc < signed'(CCW'(w_eff)));
    ring_t = (nrc_pkg::RW + 1)'(emit_ring) + (nrc_pkg::RW + 1)'(wz) +
             (nrc_pkg::RW + 1)'(nrc_pkg::RING_ROWS - nrc_pkg::HALF);
    if (ring_t >= (nrc_pkg::RW + 1)'(2 * nrc_pkg::RING_ROWS))
      ring_t = ring_t - (nrc_pkg::RW + 1)'(2 * nrc_pkg::RING_ROWS);
    else if (ring_t >= (nrc_pkg::RW + 1)'(nrc_pkg::RING_ROWS))
      ring_t = ring_t - (nrc_pkg::RW + 1)'(nrc_pkg::RING_ROWS);
    ring_w = ring_t[nrc_pkg::RW-1:0];
    rd_addr = AMW'(ring_w) * AMW'(MAX_WIDTH) + AMW'(cc[CW-1:0]);
    last_issue = (wz == nrc_pkg::KW'(nrc_pkg::KSIZE - 1)) &&
                 (wu == nrc_pkg::KW'(nrc_pkg::KSIZE - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_act <= 1'b0;
    end else if (cmd.win_start) begin
      issue_act <= 1'b1;
    end else if (issue_act && last_issue) begin
      issue_act <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_start) begin
      wz <= '0;
      wu <= '0;
      wp <= '0;
    end else if (issue_act) begin
      wp <= wp + nrc_pkg::PW'(1);
      if (wu == nrc_pkg::KW'(nrc_pkg::KSIZE - 1)) begin
        wu <= '0;
        wz <= wz + nrc_pkg::KW'(1);
      end else begin
        wu <= wu + nrc_pkg::KW'(1);
      end
    end
  end

  // line memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pix_write) mem[wr_addr] <= {item.blue, item.green, item.red};
    rd_q <= mem[rd_addr];
  end

  // tap pipeline aligned with the read data
  logic v1, l1, in_q;
  logic signed [7:0] k_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= issue_act;
    end
  end
  always_ff @(posedge clk) begin
    l1 <= last_issue;
    in_q <= in_win;
    k_q <= coef[wp];
  end

  assign status.win_done = v1 && l1;

  // multiply and accumulate per channel
  logic signed [nrc_pkg::SW-1:0] acc [3];
  logic signed [nrc_pkg::DW-1:0] dsum;
  logic signed [nrc_pkg::PRW-1:0] prod [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = $signed({1'b0, rd_q[8*c +: 8]}) * k_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_start) begin
      for (int c = 0; c < 3; c++) acc[c] <= '0;
      dsum <= '0;
    end else if (v1 && in_q) begin
      for (int c = 0; c < 3; c++) begin
        acc[c] <= acc[c] + {{(nrc_pkg::SW - nrc_pkg::PRW){prod[c][nrc_pkg::PRW-1]}}, prod[c]};
      end
      dsum <= dsum + {{(nrc_pkg::DW - 8){k_q[7]}}, k_q};
    end
  end

  // divider setup: magnitudes, sign and overflow flags
  logic [nrc_pkg::DW-1:0] d_u, b_mag;
  logic d_neg;
  logic [nrc_pkg::SW-1:0] s_u [3];
  logic [nrc_pkg::SW-1:0] a_mag [3];
  logic zero_n [3];
  logic big_n [3];

  always_comb begin
    d_u = (dsum == '0) ? nrc_pkg::DW'(1) : dsum;
    d_neg = d_u[nrc_pkg::DW-1];
    b_mag = d_neg ? (~d_u + nrc_pkg::DW'(1)) : d_u;
    for (int c = 0; c < 3; c++) begin
      s_u[c] = acc[c];
      a_mag[c] = s_u[c][nrc_pkg::SW-1] ? (~s_u[c] + nrc_pkg::SW'(1)) : s_u[c];
      zero_n[c] = (s_u[c] == '0) || (s_u[c][nrc_pkg::SW-1] != d_neg);
      big_n[c] = nrc_pkg::XW'(a_mag[c]) >= (nrc_pkg::XW'(b_mag) << 8);
    end
  end

  // eight-step restoring divider, three channels side by side
  logic div_act;
  logic [2:0] div_cnt;
  logic [nrc_pkg::XW-1:0] rem [3];
  logic [nrc_pkg::XW-1:0] bsh [3];
  logic [7:0] quo [3];
  logic zero_f [3];
  logic big_f [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_act <= 1'b0;
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_act <= 1'b1;
      div_cnt <= '0;
    end else if (div_act) begin
      div_cnt <= div_cnt + 3'd1;
      if (div_cnt == 3'd7) div_act <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      for (int c = 0; c < 3; c++) begin
        rem[c] <= nrc_pkg::XW'(a_mag[c]);
        bsh[c] <= nrc_pkg::XW'(b_mag) << 7;
        quo[c] <= '0;
        zero_f[c] <= zero_n[c];
        big_f[c] <= big_n[c];
      end
    end else if (div_act) begin
      for (int c = 0; c < 3; c++) begin
        if (rem[c] >= bsh[c]) begin
          rem[c] <= rem[c] - bsh[c];
          quo[c] <= {quo[c][6:0], 1'b1};
        end else begin
          quo[c] <= {quo[c][6:0], 1'b0};
        end
        bsh[c] <= bsh[c] >> 1;
      end
    end
  end

  assign status.div_done = div_act && (div_cnt == 3'd7);

  // clamped channel results
  logic [7:0] res [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      res[c] = zero_f[c] ? 8'd0 : (big_f[c] ? 8'd255 : quo[c]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.out_red <= res[0];
      out_data.out_green <= res[1];
      out_data.out_blue <= res[2];
      out_data.out_row <= emit_row;
      out_data.out_col <= 10'(emit_col);
      out_data.last_pixel <= ({1'b0, emit_row} == h_eff - 11'd1) &&
                             (WW'(emit_col) == w_eff - WW'(1));
    end
  end

  assign status.out_free = !out_valid;

endmodule

// ===== rtl/normalized_rgb_convolution_core.sv =====
// Top level of the normalized rgb convolution core
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_ready, in_data          | to core
//  out     | out_valid, out_ready, out_data       | from core
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | to core
//
// A coefficient write, or an item that yields no result, stays within the
// idle, execute and check states. An item that yields a result reads the 3x3
// window one tap per cycle from the single read port of the line memory, then
// an eight-step divider runs for all three channels at once.
// Reset is synchronous; the line memory and coefficients are not cleared.
// A stalled output holds in its register while the next item is accepted.
`timescale 1ns / 1ps
module normalized_rgb_convolution_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nrc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nrc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data
);

  nrc_pkg::cmd_t cmd;
  nrc_pkg::status_t status;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  nrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  nrc_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== rtl/nrc_checker.sv =====
// Port-level checker for the normalized rgb convolution core, with its bind
`timescale 1ns / 1ps
module nrc_port_checks (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input nrc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input nrc_pkg::out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // offered input holds until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // one item at a time: a transfer closes the input for the next cycle
  a_in_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a transfer");

  // a new result never appears in the cycle after an input transfer
  a_out_lag: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_valid && in_ready |=> !out_valid)
    else $error("result too early");

endmodule

bind normalized_rgb_convolution_core nrc_port_checks u_nrc_port_checks (.*);

// ===== bench/nrc_checker.sv =====
// Transfer monitor, convolution predictor and result comparator for the core
`timescale 1ns / 1ps
module nrc_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  nrc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  nrc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  output int                 pending,
  output int                 errors
);

  // predictor state
  int                 kernel_coef [nrc_pkg::KK];
  logic [23:0]        row_ring [nrc_pkg::RING_ROWS][MAX_WIDTH];
  int unsigned        in_row, in_col, emit_row, emit_col;
  bit                 frame_done;
  logic [10:0]        width_reg, height_reg;
  nrc_pkg::out_item_t pixel_q [$];

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > nrc_pkg::MAX_HEIGHT) return nrc_pkg::MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    in_row = 0;
    in_col = 0;
    emit_row = 0;
    emit_col = 0;
    frame_done = 0;
  endfunction

  function automatic logic [7:0] clamp_quot(int sum, int dv);
    int q;
    q = sum / dv;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  // produce the next output pixel if its window is complete
  function automatic bit emit_pixel(output nrc_pkg::out_item_t o);
    int unsigned w, h, nr, nc;
    int sr, sg, sb, dv, rr, cc, k;
    logic [23:0] px;
    w = eff_width();
    h = eff_height();
    o = '0;
    if (!frame_done) begin
      nr = emit_row + nrc_pkg::HALF;
      nc = emit_col + nrc_pkg::HALF;
      if (nr > h - 1) nr = h - 1;
      if (nc > w - 1) nc = w - 1;
      if (!(nr < in_row || (nr == in_row && nc < in_col))) return 0;
    end
    sr = 0; sg = 0; sb = 0; dv = 0;
    for (int z = 0; z < nrc_pkg::KSIZE; z++) begin
      for (int u = 0; u < nrc_pkg::KSIZE; u++) begin
        rr = int'(emit_row) - nrc_pkg::HALF + z;
        cc = int'(emit_col) - nrc_pkg::HALF + u;
        if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
          px = row_ring[rr % nrc_pkg::RING_ROWS][cc % MAX_WIDTH];
          k = kernel_coef[z * nrc_pkg::KSIZE + u];
          sr += int'(px[7:0]) * k;
          sg += int'(px[15:8]) * k;
          sb += int'(px[23:16]) * k;
          dv += k;
        end
      end
    end
    if (dv == 0) dv = 1;
    o.out_red = clamp_quot(sr, dv);
    o.out_green = clamp_quot(sg, dv);
    o.out_blue = clamp_quot(sb, dv);
    o.out_row = emit_row[9:0];
    o.out_col = emit_col[9:0];
    o.last_pixel = (emit_row == h - 1 && emit_col == w - 1);
    emit_col++;
    if (emit_col >= w) begin
      emit_col = 0;
      emit_row++;
      if (emit_row >= h) restart_frame();
    end
    return 1;
  endfunction

  // apply one accepted input item
  function automatic void take_item(nrc_pkg::in_item_t d);
    nrc_pkg::out_item_t o;
    case (d.req_type)
      nrc_pkg::REQ_COEF: begin
        if (d.coef_index < nrc_pkg::KK)
          kernel_coef[d.coef_index] = int'($signed(d.coef_value));
      end
      nrc_pkg::REQ_PIXEL: begin
        if (!frame_done) begin
          row_ring[in_row % nrc_pkg::RING_ROWS][in_col % MAX_WIDTH] = {d.blue, d.green, d.red};
          in_col++;
          if (in_col >= eff_width()) begin
            in_col = 0;
            in_row++;
            if (in_row >= eff_height()) frame_done = 1;
          end
        end
        if (emit_pixel(o)) pixel_q.push_back(o);
      end
      nrc_pkg::REQ_FLUSH: begin
        if (emit_pixel(o)) pixel_q.push_back(o);
      end
      default: ;
    endcase
  endfunction

  initial errors = 0;

  // track reset, configuration and input transfers; check every output field
  always @(posedge clk) begin
    nrc_pkg::out_item_t want;
    if (rst) begin
      width_reg = 11'd1024;
      height_reg = 11'd1024;
      restart_frame();
      pixel_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == nrc_pkg::CFG_WIDTH) begin
          width_reg = cfg_data;
          restart_frame();
          pixel_q.delete();
        end else if (cfg_index == nrc_pkg::CFG_HEIGHT) begin
          height_reg = cfg_data;
          restart_frame();
          pixel_q.delete();
        end
      end
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected output transfer, actual %p", $time, out_data);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (out_data !== want) begin
            $display("%0t: output mismatch, expected %p, actual %p", $time, want, out_data);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) take_item(in_data);
    end
    pending <= pixel_q.size();
  end
endmodule

// ===== bench/tb_normalized_rgb_convolution_core.sv =====
// Stimulus, clocking and verdict for the normalized rgb convolution core
`timescale 1ns / 1ps
module tb_normalized_rgb_convolution_core;

  localparam int MAX_W = 1024;
  localparam int ITEM_GOAL = 1900;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd2;

  logic               clk;
  logic               rst;
  logic               in_valid, in_ready;
  nrc_pkg::in_item_t  in_data;
  logic               out_valid, out_ready;
  nrc_pkg::out_item_t out_data;
  logic               cfg_valid, cfg_ready;
  logic [1:0]         cfg_index;
  logic [10:0]        cfg_data;
  int                 pending, errors;
  int                 items_sent;
  int                 cycles;
  bit                 quiet;

  normalized_rgb_convolution_core #(.MAX_WIDTH(MAX_W)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  nrc_checker #(.MAX_WIDTH(MAX_W)) i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: short random stalls plus one long hold-off
  initial begin
    int stall;
    int ticks;
    out_ready = 0;
    stall = 0;
    ticks = 0;
    forever begin
      @(posedge clk);
      ticks++;
      if (ticks == 3000) stall = 400;
      if (stall > 0) begin
        out_ready <= 0;
        stall--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 0;
        stall = $urandom_range(0, 2);
      end else begin
        out_ready <= 1;
      end
    end
  end

  function automatic nrc_pkg::in_item_t make_item(logic [1:0] req);
    nrc_pkg::in_item_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(nrc_pkg::in_item_t)-1:0];
    it.req_type = req;
    return it;
  endfunction

  // one input transfer, with an occasional gap in front
  task automatic send(input nrc_pkg::in_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (items_sent > ITEM_GOAL - 200) quiet = 1;
  endtask

  task automatic send_coef(input int idx, input int val);
    nrc_pkg::in_item_t it;
    it = make_item(nrc_pkg::REQ_COEF);
    it.coef_index = idx[3:0];
    it.coef_value = val[7:0];
    send(it);
  endtask

  // wait until every expected pixel is out and the core is quiet
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[10:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // one frame setting: mostly pixels, then enough flushes to empty it
  task automatic run_frame(input int w, input int h, input int count, input bit new_kernel);
    int ew, r;
    write_reg(nrc_pkg::CFG_WIDTH, w);
    write_reg(nrc_pkg::CFG_HEIGHT, h);
    if (new_kernel) begin
      for (int i = 0; i < nrc_pkg::KK; i++)
        send_coef(i, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6));
    end
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85) send(make_item(nrc_pkg::REQ_PIXEL));
      else if (r < 95) send(make_item(nrc_pkg::REQ_FLUSH));
      else if (r < 98) send_coef($urandom_range(0, 15), $urandom_range(0, 255));
      else send(make_item(REQ_NONE));
    end
    ew = (w == 0) ? 1 : (w > MAX_W) ? MAX_W : w;
    for (int i = 0; i < ew + 3; i++) send(make_item(nrc_pkg::REQ_FLUSH));
  endtask

  initial begin
    nrc_pkg::in_item_t it;
    int w, h;
    rst = 1;
    quiet = 0;
    items_sent = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = nrc_pkg::CFG_WIDTH;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // nothing ready yet: flush and reserved request give no output
    send(make_item(nrc_pkg::REQ_FLUSH));
    send(make_item(REQ_NONE));
    // kernel with both coefficient extremes, then out-of-range indexes
    send_coef(0, 1); send_coef(1, 2); send_coef(2, 1);
    send_coef(3, 2); send_coef(4, -128); send_coef(5, 2);
    send_coef(6, 1); send_coef(7, 2); send_coef(8, 127);
    send_coef(9, 55); send_coef(15, -1);
    write_reg(CFG_SPARE, 2047);
    write_reg(nrc_pkg::CFG_WIDTH, 4);
    write_reg(nrc_pkg::CFG_HEIGHT, 3);
    // full 4x3 frame of extreme channel values
    for (int i = 0; i < 12; i++) begin
      it = make_item(nrc_pkg::REQ_PIXEL);
      it.red = (i % 2) ? 8'hFF : 8'h00;
      it.green = (i % 3) ? 8'h00 : 8'hFF;
      it.blue = (i < 6) ? 8'hFF : 8'h00;
      send(it);
    end
    // pixel after the frame is in: dropped, one output drains
    send(make_item(nrc_pkg::REQ_PIXEL));
    for (int i = 0; i < 6; i++) send(make_item(nrc_pkg::REQ_FLUSH));

    // register extremes: zero acts as one, above max clamps
    run_frame(0, 0, 3, 0);
    run_frame(2047, 1, 700, 0);
    run_frame(1, 2047, 40, 1);
    // kernel whose coefficients cancel: a full window's divisor becomes one
    for (int i = 0; i < nrc_pkg::KK; i++) send_coef(i, 0);
    send_coef(3, -7);
    send_coef(5, 7);
    run_frame(5, 4, 22, 0);

    // random frames, mostly small
    while (items_sent < ITEM_GOAL) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      run_frame(w, h, w * h + $urandom_range(0, w * h / 2 + 3), $urandom_range(0, 2) == 0);
    end

    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
